// ===== rtl/csq_pkg.sv =====
package csq_pkg;

	localparam int QUEUE_DEPTH    = 16;
	localparam int THREAD_ID_BITS = 8;

	localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int ID_W     = THREAD_ID_BITS;
	localparam int OP_W     = 3;
	localparam int TID_W    = 8;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 16;
	localparam int INIT_W   = 15;

	localparam logic [OP_W-1:0] OP_WAIT     = 3'd0;
	localparam logic [OP_W-1:0] OP_SIGNAL   = 3'd1;
	localparam logic [OP_W-1:0] OP_WAKE_ALL = 3'd2;
	localparam logic [OP_W-1:0] OP_CLOSE    = 3'd3;
	localparam logic [OP_W-1:0] OP_OPEN     = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_DONE     = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_BLOCKED  = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_CLOSED   = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 3'd4;

	// Thread ids are kept in ID_W bits; the channel field is TID_W bits wide.
	function automatic logic [ID_W-1:0] field_to_id(input logic [TID_W-1:0] x);
		logic [ID_W-1:0] r;
		r = '0;
		for (int i = 0; i < ID_W; i++) begin
			if (i < TID_W) r[i] = x[i];
		end
		return r;
	endfunction

	function automatic logic [TID_W-1:0] id_to_field(input logic [ID_W-1:0] x);
		logic [TID_W-1:0] r;
		r = '0;
		for (int i = 0; i < TID_W; i++) begin
			if (i < ID_W) r[i] = x[i];
		end
		return r;
	endfunction

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) r = '0;
		else r = p + PTR_W'(1);
		return r;
	endfunction

endpackage

// ===== rtl/csq_if.sv =====
interface csq_req_if;
	logic                          valid;
	logic                          ready;
	logic [csq_pkg::OP_W-1:0]      operation;
	logic [csq_pkg::TID_W-1:0]     thread_id;

	modport source (output valid, output operation, output thread_id, input ready);
	modport sink   (input valid, input operation, input thread_id, output ready);
endinterface

interface csq_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [csq_pkg::STATUS_W-1:0]  status;
	logic                          woken_valid;
	logic [csq_pkg::TID_W-1:0]     woken_thread;
	logic                          last;

	modport source (output valid, output status, output woken_valid, output woken_thread,
		output last, input ready);
	modport sink   (input valid, input status, input woken_valid, input woken_thread,
		input last, output ready);
endinterface

// ===== rtl/csq_ram.sv =====
module csq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

// ===== rtl/counting_semaphore_wait_queue_unit.sv =====
// Counting semaphore with a FIFO queue of waiting thread ids.
// The req channel carries one word per operation (wait, signal, wake all,
// close, open) with the calling thread id; the rsp channel returns result
// words with status, the released thread and a last flag. Every operation
// gives one word, except wake all with queued threads, which gives one word per queued thread.
// cfg_we/cfg_wdata load the count that open restores.
// A word is taken only while the sequencer is idle. Operations that do not
// release a thread are accepted in the idle state, then decided in the exec
// state, which loads the output register. Releasing a thread adds a read
// state for the queue memory (one read port, registered read); wake all then
// delivers one word per cycle while the receiver keeps ready high.
// The output register lets a new word be accepted while a result still
// waits to be taken. When the receiver stalls, the sequencer holds its
// pending result until the output register frees, and nothing is lost.
// Reset clears the count, the closed flag and the queue pointers at once;
// the queue memory itself needs no clearing, since only filled entries
// are ever read.
module counting_semaphore_wait_queue_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [csq_pkg::INIT_W-1:0]     cfg_wdata,
	csq_req_if.sink                        req,
	csq_rsp_if.source                      rsp
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;

	logic [1:0]                        state_q, state_d;
	logic [csq_pkg::OP_W-1:0]          op_q;
	logic [csq_pkg::ID_W-1:0]          tid_q;
	logic [csq_pkg::INIT_W-1:0]        init_q;
	logic [csq_pkg::COUNT_W-1:0]       count_q, count_d;
	logic                              closed_q, closed_d;
	logic [csq_pkg::PTR_W-1:0]         head_q, head_d, tail_q, tail_d;
	logic [csq_pkg::FILL_W-1:0]        fill_q, fill_d;

	logic                              out_valid_q;
	logic [csq_pkg::STATUS_W-1:0]      out_status_q;
	logic                              out_wvalid_q;
	logic [csq_pkg::TID_W-1:0]         out_thread_q;
	logic                              out_last_q;

	logic                              res_load;
	logic [csq_pkg::STATUS_W-1:0]      res_status;
	logic                              res_wvalid;
	logic [csq_pkg::TID_W-1:0]         res_thread;
	logic                              res_last;

	logic                              ram_we, ram_re;
	logic [csq_pkg::PTR_W-1:0]         ram_raddr;
	logic [csq_pkg::ID_W-1:0]          ram_rdata;

	logic slot_free, count_min, count_max, count_le0, ring_full, ring_empty, needs_pop;

	assign req.ready = (state_q == S_IDLE);
	assign slot_free = !out_valid_q || rsp.ready;

	assign count_min  = (count_q == 16'h8000);
	assign count_max  = (count_q == 16'h7fff);
	assign count_le0  = count_q[csq_pkg::COUNT_W-1] || (count_q == '0);
	assign ring_full  = (fill_q >= csq_pkg::FILL_W'(csq_pkg::QUEUE_DEPTH));
	assign ring_empty = (fill_q == '0);

	// A signal on a negative count or a wake all with waiters must read the ring.
	assign needs_pop = !closed_q && !ring_empty &&
		((op_q == csq_pkg::OP_SIGNAL && !count_max && count_q[csq_pkg::COUNT_W-1]) ||
		 (op_q == csq_pkg::OP_WAKE_ALL));

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		closed_d   = closed_q;
		head_d     = head_q;
		tail_d     = tail_q;
		fill_d     = fill_q;
		res_load   = 1'b0;
		res_status = csq_pkg::STATUS_DONE;
		res_wvalid = 1'b0;
		res_thread = '0;
		res_last   = 1'b1;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = head_q;

		unique case (state_q)
			S_IDLE: begin
				if (req.valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (needs_pop) begin
					ram_re  = 1'b1;
					state_d = S_READ;
				end else if (slot_free) begin
					res_load = 1'b1;
					state_d  = S_IDLE;
					if (op_q == csq_pkg::OP_OPEN) begin
						count_d  = {1'b0, init_q};
						closed_d = 1'b0;
						head_d   = '0;
						tail_d   = '0;
						fill_d   = '0;
					end else if (op_q > csq_pkg::OP_OPEN) begin
						res_status = csq_pkg::STATUS_DONE;
					end else if (closed_q) begin
						res_status = csq_pkg::STATUS_CLOSED;
					end else begin
						unique case (op_q)
							csq_pkg::OP_WAIT: begin
								if (count_min) begin
									res_status = csq_pkg::STATUS_OVERFLOW;
								end else if (count_le0) begin
									if (ring_full) begin
										res_status = csq_pkg::STATUS_FULL;
									end else begin
										res_status = csq_pkg::STATUS_BLOCKED;
										count_d    = count_q - 16'd1;
										ram_we     = 1'b1;
										tail_d     = csq_pkg::ptr_inc(tail_q);
										fill_d     = fill_q + csq_pkg::FILL_W'(1);
									end
								end else begin
									count_d = count_q - 16'd1;
								end
							end
							csq_pkg::OP_SIGNAL: begin
								if (count_max) res_status = csq_pkg::STATUS_OVERFLOW;
								else count_d = count_q + 16'd1;
							end
							csq_pkg::OP_CLOSE: begin
								closed_d = 1'b1;
								head_d   = '0;
								tail_d   = '0;
								fill_d   = '0;
							end
							default: begin
								// Wake all on an empty queue reports done.
								res_status = csq_pkg::STATUS_DONE;
							end
						endcase
					end
				end
			end
			S_READ: begin
				if (slot_free) begin
					res_load   = 1'b1;
					res_wvalid = 1'b1;
					res_thread = csq_pkg::id_to_field(ram_rdata);
					head_d     = csq_pkg::ptr_inc(head_q);
					fill_d     = fill_q - csq_pkg::FILL_W'(1);
					if (op_q == csq_pkg::OP_SIGNAL) begin
						count_d = count_q + 16'd1;
						state_d = S_IDLE;
					end else if (fill_q > csq_pkg::FILL_W'(1)) begin
						// Fetch the next waiter while this word goes out.
						res_last  = 1'b0;
						ram_re    = 1'b1;
						ram_raddr = csq_pkg::ptr_inc(head_q);
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			init_q      <= '0;
			count_q     <= '0;
			closed_q    <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			closed_q <= closed_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			fill_q   <= fill_d;
			if (cfg_we) init_q <= cfg_wdata;
			if (res_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q  <= req.operation;
			tid_q <= csq_pkg::field_to_id(req.thread_id);
		end
		if (res_load) begin
			out_status_q <= res_status;
			out_wvalid_q <= res_wvalid;
			out_thread_q <= res_thread;
			out_last_q   <= res_last;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.woken_valid  = out_wvalid_q;
	assign rsp.woken_thread = out_thread_q;
	assign rsp.last         = out_last_q;

	csq_ram #(
		.WIDTH (csq_pkg::ID_W),
		.DEPTH (csq_pkg::QUEUE_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (tid_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
